### rtl/core/pd_line_follow_motor_drive_top_macros.svh
// assertion helpers shared by the rtl
`ifndef PD_LINE_FOLLOW_MOTOR_DRIVE_TOP_MACROS_SVH
`define PD_LINE_FOLLOW_MOTOR_DRIVE_TOP_MACROS_SVH

// property checked on every clock, off during reset
`define PD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pd assertion failed");

// consequent must hold in the cycle after the antecedent
`define PD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pd assertion failed");

`endif

### rtl/core/pd_lf_pkg.sv
package pd_lf_pkg;

  localparam int unsigned SumW  = 13;
  localparam int unsigned QuoW  = 12;
  localparam int unsigned ErrW  = 12;
  localparam int unsigned OpAW  = 14;
  localparam int unsigned OpBW  = 11;
  localparam int unsigned AccW  = 22;
  localparam int unsigned DivSteps = QuoW;
  localparam int unsigned CntW  = $clog2(DivSteps);

  typedef enum logic [3:0] {
    CFG_WEIGHT_CENTER = 4'd0,
    CFG_WEIGHT_INNER  = 4'd1,
    CFG_WEIGHT_OUTER  = 4'd2,
    CFG_GAIN_P        = 4'd3,
    CFG_GAIN_D        = 4'd4,
    CFG_BASE_POWER    = 4'd5,
    CFG_TRIM_LEFT     = 4'd6,
    CFG_TRIM_RIGHT    = 4'd7
  } cfg_idx_e;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DIV   = 8'b0000_0010,
    S_MUL_P = 8'b0000_0100,
    S_MUL_D = 8'b0000_1000,
    S_CORR  = 8'b0001_0000,
    S_MUL_L = 8'b0010_0000,
    S_MUL_R = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef struct packed {
    logic en;
    logic clr;
  } mac_ctrl_t;

endpackage

### rtl/core/pd_lf_div.sv
module pd_lf_div
  import pd_lf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [QuoW-1:0]   dividend_i,
  input  logic [2:0]        divisor_i,
  output div_status_t       status_o,
  output logic [QuoW-1:0]   quotient_o
);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [1:0]      rem_q, rem_d;
  logic [QuoW-1:0] quo_q, quo_d;
  logic [2:0]      divisor_q, divisor_d;
  logic [2:0]      trial;
  logic            ge;

  // restoring division, one quotient bit per cycle while busy
  always_comb begin
    trial     = {rem_q, quo_q[QuoW-1]};
    ge        = (trial >= divisor_q);
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    divisor_d = divisor_q;
    if (start_i) begin
      busy_d    = 1'b1;
      cnt_d     = '0;
      rem_d     = '0;
      quo_d     = dividend_i;
      divisor_d = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? 2'(trial - divisor_q) : trial[1:0];
      quo_d = {quo_q[QuoW-2:0], ge};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    divisor_q <= divisor_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = quo_q;

endmodule

### rtl/core/pd_lf_mac.sv
module pd_lf_mac
  import pd_lf_pkg::*;
(
  input  logic                   clk_i,
  input  mac_ctrl_t              ctrl_i,
  input  logic signed [OpAW-1:0] a_i,
  input  logic [OpBW-1:0]        b_i,
  output logic signed [AccW-1:0] acc_o
);

  logic signed [AccW-1:0]      acc_q, acc_d;
  logic signed [OpAW+OpBW:0]   prod;

  always_comb begin
    prod  = a_i * $signed({1'b0, b_i});
    acc_d = (ctrl_i.clr ? '0 : acc_q) + prod[AccW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

### rtl/core/pd_line_follow_motor_drive_top.sv
// channel   | ports            | fields, low bit first
// ----------+------------------+------------------------------------------------
// sensors   | s_axis_*         | tdata: outer_left, inner_left, middle, inner_right, outer_right
// drive     | m_axis_*         | tdata: left_duty, left_forward, right_duty, right_forward
// config    | cfg_*            | index 0..7, data up to 11 bits, always ready
//
// one sample runs from acceptance to a valid drive transaction through a bit-serial divider,
// signing of the error as the divider finishes, four shared multiplier steps, one clamp step
// and one output load; a new sample is taken only once the last one is through its output load
// the next sample is taken while a finished transaction waits on m_axis_tready_i
// a transaction still waiting holds the next sample in its output load step
// asynchronous active-low reset clears control and the previous error and loads config defaults

`include "pd_line_follow_motor_drive_top_macros.svh"

module pd_line_follow_motor_drive_top
  import pd_lf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // outer_left, inner_left, middle, inner_right,
                                        // outer_right, 3 unused bits
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // left_duty[7:0], left_forward, right_duty[7:0],
                                        // right_forward, 6 zero bits
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [9:0]  weight_center_q, weight_inner_q, weight_outer_q;
  logic [7:0]  gain_p_q, gain_d_q, base_power_q;
  logic [10:0] trim_left_q, trim_right_q;

  logic signed [ErrW-1:0] prev_err_q, prev_err_d;
  logic signed [ErrW-1:0] err_q, err_d;
  logic                   neg_q, zero_cnt_q;
  logic signed [9:0]      vl_q, vr_q, vl_d, vr_d;
  logic [7:0]             duty_l_q;
  logic                   out_valid_q;
  logic [23:0]            out_data_q;

  logic signed [SumW-1:0] sum;
  logic [SumW-1:0]        sum_mag;
  logic [2:0]             cnt;
  logic                   accept;

  div_status_t            div_stat;
  logic [QuoW-1:0]        quotient;

  mac_ctrl_t              mac_ctrl;
  logic signed [OpAW-1:0] mac_a;
  logic [OpBW-1:0]        mac_b;
  logic signed [AccW-1:0] acc;

  logic signed [AccW-1:0] acc_adj;
  logic signed [13:0]     corr;
  logic signed [14:0]     sum_l, sum_r;
  logic [7:0]             mag_l, mag_r;
  logic [7:0]             duty_r;
  logic                   fwd_l, fwd_r;
  logic                   out_load;

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_center_q <= 10'd0;
      weight_inner_q  <= 10'd128;
      weight_outer_q  <= 10'd768;
      gain_p_q        <= 8'd20;
      gain_d_q        <= 8'd60;
      base_power_q    <= 8'd150;
      trim_left_q     <= 11'd1024;
      trim_right_q    <= 11'd1085;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WEIGHT_CENTER: weight_center_q <= cfg_data_i[9:0];
        CFG_WEIGHT_INNER:  weight_inner_q  <= cfg_data_i[9:0];
        CFG_WEIGHT_OUTER:  weight_outer_q  <= cfg_data_i[9:0];
        CFG_GAIN_P:        gain_p_q        <= cfg_data_i[7:0];
        CFG_GAIN_D:        gain_d_q        <= cfg_data_i[7:0];
        CFG_BASE_POWER:    base_power_q    <= cfg_data_i[7:0];
        CFG_TRIM_LEFT:     trim_left_q     <= cfg_data_i;
        CFG_TRIM_RIGHT:    trim_right_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // weighted sensor sum and side count
  always_comb begin
    sum = (s_axis_tdata_i[2] ? $signed({3'b0, weight_center_q}) : '0)
        + (s_axis_tdata_i[3] ? $signed({3'b0, weight_inner_q})  : '0)
        + (s_axis_tdata_i[4] ? $signed({3'b0, weight_outer_q})  : '0)
        - (s_axis_tdata_i[1] ? $signed({3'b0, weight_inner_q})  : '0)
        - (s_axis_tdata_i[0] ? $signed({3'b0, weight_outer_q})  : '0);
    sum_mag = sum[SumW-1] ? SumW'(-sum) : SumW'(sum);
    cnt = 3'(s_axis_tdata_i[0]) + 3'(s_axis_tdata_i[1])
        + 3'(s_axis_tdata_i[3]) + 3'(s_axis_tdata_i[4]);
  end

  pd_lf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (sum_mag[QuoW-1:0]),
    .divisor_i  (cnt),
    .status_o   (div_stat),
    .quotient_o (quotient)
  );

  pd_lf_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (acc)
  );

  // correction and wheel values
  always_comb begin
    acc_adj = acc + (acc[AccW-1] ? AccW'(255) : AccW'(0));
    corr    = 14'(acc_adj >>> 8);
    sum_l   = $signed({7'b0, base_power_q}) + 15'(corr);
    sum_r   = $signed({7'b0, base_power_q}) - 15'(corr);
    if (sum_l > 15'sd255) begin
      vl_d = 10'sd255;
    end else if (sum_l < -15'sd255) begin
      vl_d = -10'sd255;
    end else begin
      vl_d = 10'(sum_l);
    end
    if (sum_r > 15'sd255) begin
      vr_d = 10'sd255;
    end else if (sum_r < -15'sd255) begin
      vr_d = -10'sd255;
    end else begin
      vr_d = 10'(sum_r);
    end
    mag_l  = vl_q[9] ? 8'(-vl_q) : vl_q[7:0];
    mag_r  = vr_q[9] ? 8'(-vr_q) : vr_q[7:0];
    duty_r = (|acc[AccW-1:18]) ? 8'd255 : acc[17:10];
    fwd_l  = !(vl_q[9] && (trim_left_q != '0));
    fwd_r  = !(vr_q[9] && (trim_right_q != '0));
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    err_d      = err_q;
    prev_err_d = prev_err_q;
    mac_ctrl   = '0;
    mac_a      = '0;
    mac_b      = '0;
    out_load   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          if (zero_cnt_q) begin
            err_d = '0;
          end else begin
            err_d = neg_q ? ErrW'(-quotient) : ErrW'(quotient);
          end
          state_d = S_MUL_P;
        end
      end
      S_MUL_P: begin
        mac_ctrl = '{en: 1'b1, clr: 1'b1};
        mac_a    = OpAW'(err_q);
        mac_b    = {3'b0, gain_p_q};
        state_d  = S_MUL_D;
      end
      S_MUL_D: begin
        mac_ctrl   = '{en: 1'b1, clr: 1'b0};
        mac_a      = OpAW'(err_q) - OpAW'(prev_err_q);
        mac_b      = {3'b0, gain_d_q};
        prev_err_d = err_q;
        state_d    = S_CORR;
      end
      S_CORR: begin
        state_d = S_MUL_L;
      end
      S_MUL_L: begin
        mac_ctrl = '{en: 1'b1, clr: 1'b1};
        mac_a    = OpAW'(mag_l);
        mac_b    = trim_left_q;
        state_d  = S_MUL_R;
      end
      S_MUL_R: begin
        mac_ctrl = '{en: 1'b1, clr: 1'b1};
        mac_a    = OpAW'(mag_r);
        mac_b    = trim_right_q;
        state_d  = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prev_err_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      prev_err_q <= prev_err_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    err_q <= err_d;
    if (accept) begin
      neg_q      <= sum[SumW-1];
      zero_cnt_q <= (cnt == 3'd0);
    end
    if (state_q == S_CORR) begin
      vl_q <= vl_d;
      vr_q <= vr_d;
    end
    if (state_q == S_MUL_R) begin
      duty_l_q <= (|acc[AccW-1:18]) ? 8'd255 : acc[17:10];
    end
    if (out_load) begin
      out_data_q <= {6'b0, fwd_r, duty_r, fwd_l, duty_l_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  `PD_ASSERT_NEXT(a_accept_starts_div, clk_i, rst_ni, accept, (state_q == S_DIV) && div_stat.busy)
  `PD_ASSERT(a_done_only_in_div, clk_i, rst_ni, div_stat.done |-> (state_q == S_DIV))
  `PD_ASSERT_NEXT(a_fin_loads_output, clk_i, rst_ni, out_load, m_axis_tvalid_o && (state_q == S_IDLE))

endmodule
